// File: design/mtep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and codes for the track event parser: parse phases, result
// kinds, status constants and the per-track state and result records.
// ----------------------------------------------------------------------------
package mtep_pkg;

    // parse phase codes
    localparam logic [2:0] PH_DELTA   = 3'd0;
    localparam logic [2:0] PH_STATUS  = 3'd1;
    localparam logic [2:0] PH_DATA1   = 3'd2;
    localparam logic [2:0] PH_DATA2   = 3'd3;
    localparam logic [2:0] PH_MTYPE   = 3'd4;
    localparam logic [2:0] PH_LEN     = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;

    // result kinds
    localparam logic [2:0] K_CHANNEL   = 3'd0;
    localparam logic [2:0] K_TEMPO     = 3'd1;
    localparam logic [2:0] K_END       = 3'd2;
    localparam logic [2:0] K_UNDEFINED = 3'd3;
    localparam logic [2:0] K_UNHANDLED = 3'd4;
    localparam logic [2:0] K_BAD_LEN   = 3'd5;

    // status bytes and meta codes
    localparam logic [7:0] ST_META       = 8'hFF;
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] ST_REALTIME   = 8'hF8;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;

    // parser state kept across bytes (pulse total is held separately)
    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  last_status;
        logic [27:0] varlen_accum;
        logic [2:0]  varlen_bytes;
        logic [27:0] payload_remaining;
        logic [7:0]  meta_kind;
        logic [7:0]  held_status;
        logic [7:0]  held_data;
        logic [23:0] tempo_capture;
        logic [23:0] tempo_current;
        logic        halted;
    } t_state;

    // one result item (pulse count travels beside it)
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [1:0]  data_count;
        logic [23:0] tempo_value;
        logic        track_ended;
    } t_result;

endpackage

// File: design/midi_track_event_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses track chunk payload bytes into channel messages, tempo changes and
// track end or error reports.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one track byte per
//   transfer with first-byte and last-byte marks. Output channel
//   (o_out_valid / i_out_ready) carries at most one result per byte; bytes
//   that finish nothing (delta bytes, skipped meta or sysex payload) give
//   no result.
//   The byte is held in the input register, and its result is loaded
//   into the result register once that register is free or draining;
//   the result register drives o_out_valid. Throughput: one byte per
//   cycle while the receiver does not stall, set by the combinational
//   state update between the two registers.
//   Reset clears the parser to the start-of-track state with tempo 500000
//   and empties both registers.
//   When the receiver stalls, the result register holds; the byte in the
//   input register waits, and o_in_ready drops once it is full, so at most
//   one byte and one result are held inside the block.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
    parameter int PULSE_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_byte_value,
    input  logic                  i_track_start,
    input  logic                  i_track_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_kind,
    output logic [7:0]            o_status_byte,
    output logic [7:0]            o_first_data,
    output logic [7:0]            o_second_data,
    output logic [1:0]            o_data_count,
    output logic [PULSE_BITS-1:0] o_pulse_count,
    output logic [23:0]           o_tempo_value,
    output logic                  o_track_ended
);
    import mtep_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_start;
    logic                  r_in_last;
    t_state                r_state;
    t_state                n_state;
    logic [PULSE_BITS-1:0] r_pulse;
    logic [PULSE_BITS-1:0] n_pulse;
    logic                  r_out_valid;
    t_result               r_out;
    logic [PULSE_BITS-1:0] r_out_pulse;
    logic                  res_valid;
    t_result               res;
    logic                  proc;

    // byte is consumed when the result register is free or draining
    assign proc       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_byte_value;
            r_in_start <= i_track_start;
            r_in_last  <= i_track_last;
        end
    end

    // per-byte step logic
    mtep_step #(
        .PULSE_BITS (PULSE_BITS)
    ) u_step (
        .i_state        (r_state),
        .i_pulse        (r_pulse),
        .i_byte_value   (r_in_byte),
        .i_track_start  (r_in_start),
        .i_track_last   (r_in_last),
        .o_state        (n_state),
        .o_pulse        (n_pulse),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase             <= PH_DELTA;
            r_state.last_status       <= ST_META;
            r_state.varlen_accum      <= '0;
            r_state.varlen_bytes      <= '0;
            r_state.payload_remaining <= '0;
            r_state.meta_kind         <= '0;
            r_state.held_status       <= '0;
            r_state.held_data         <= '0;
            r_state.tempo_capture     <= '0;
            r_state.tempo_current     <= TEMPO_DEFAULT;
            r_state.halted            <= 1'b0;
            r_pulse                   <= '0;
        end else if (proc) begin
            r_state <= n_state;
            r_pulse <= n_pulse;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res_valid) begin
            r_out       <= res;
            r_out_pulse <= n_pulse;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_status_byte = r_out.status_byte;
    assign o_first_data  = r_out.first_data;
    assign o_second_data = r_out.second_data;
    assign o_data_count  = r_out.data_count;
    assign o_pulse_count = r_out_pulse;
    assign o_tempo_value = r_out.tempo_value;
    assign o_track_ended = r_out.track_ended;

`ifndef NO_ASSERTIONS
    // a result that closes the track leaves the parser halted
    a_end_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && res_valid && res.track_ended |=> r_state.halted)
        else $error("track end did not halt parser");

    // a halted parser gives nothing until the next track start
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_state.halted && !r_in_start |-> !res_valid)
        else $error("result produced while halted");

    // channel messages carry one or two data bytes
    a_chan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == K_CHANNEL |-> (o_data_count == 2'd1 || o_data_count == 2'd2))
        else $error("channel message with bad data count");

    // a reported tempo is never zero
    a_tempo_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == K_TEMPO |-> o_tempo_value != 24'h0)
        else $error("zero tempo reported");
`endif

endmodule

// File: design/mtep_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_step
// Combinational per-byte step: from the current parser state and one track
// byte, forms the next state and at most one result item.
// ----------------------------------------------------------------------------
module mtep_step #(
    parameter int PULSE_BITS = 48
) (
    input  mtep_pkg::t_state        i_state,
    input  logic [PULSE_BITS-1:0]   i_pulse,
    input  logic [7:0]              i_byte_value,
    input  logic                    i_track_start,
    input  logic                    i_track_last,
    output mtep_pkg::t_state        o_state,
    output logic [PULSE_BITS-1:0]   o_pulse,
    output logic                    o_result_valid,
    output mtep_pkg::t_result       o_result
);
    import mtep_pkg::*;

    t_state                s;
    logic [PULSE_BITS-1:0] pulse;
    logic [2:0]            ph;
    logic [27:0]           vl_acc;
    logic [2:0]            vl_cnt;
    logic [7:0]            ev;
    logic                  is_tempo_meta;
    logic                  res, done, end_trk;
    logic [2:0]            errk;
    logic [2:0]            kind;
    logic [7:0]            st, d1, d2;
    logic [1:0]            cnt;
    logic [23:0]           tempo_fixed;

    always_comb begin
        s     = i_state;
        pulse = i_pulse;
        // track start clears pulse, running status and halt
        if (i_track_start) begin
            pulse            = '0;
            s.last_status    = ST_META;
            s.halted         = 1'b0;
            s.phase          = PH_DELTA;
            s.varlen_accum   = '0;
            s.varlen_bytes   = '0;
        end
        ph     = s.phase;
        vl_acc = {s.varlen_accum[20:0], i_byte_value[6:0]};
        vl_cnt = s.varlen_bytes + 3'd1;
        ev     = i_byte_value[7] ? i_byte_value : s.last_status;
        if (!ev[7]) begin
            ev = 8'h00;
        end
        is_tempo_meta = (s.held_status == ST_META) && (s.meta_kind == META_TEMPO);
        res         = 1'b0;
        done        = 1'b0;
        end_trk     = 1'b0;
        errk        = K_CHANNEL;
        kind        = K_CHANNEL;
        st          = 8'h00;
        d1          = 8'h00;
        d2          = 8'h00;
        cnt         = 2'd0;
        tempo_fixed = 24'h0;

        if (!s.halted) begin
            // per-phase byte handling
            unique case (ph)
                PH_DELTA: begin
                    s.varlen_accum = vl_acc;
                    s.varlen_bytes = vl_cnt;
                    if (!i_byte_value[7]) begin
                        pulse          = pulse + {{(PULSE_BITS-28){1'b0}}, vl_acc};
                        s.varlen_accum = '0;
                        s.varlen_bytes = '0;
                        if (i_track_last) begin
                            end_trk = 1'b1;
                        end else begin
                            s.phase = PH_STATUS;
                        end
                    end else if (vl_cnt >= 3'd4 || i_track_last) begin
                        end_trk = 1'b1;
                    end
                end
                PH_STATUS: begin
                    if (ev[7:4] == 4'hF) begin
                        if (ev == ST_META) begin
                            s.held_status = ev;
                            s.phase       = PH_MTYPE;
                            if (i_track_last) errk = K_BAD_LEN;
                        end else if (ev == ST_SYSEX || ev == ST_SYSEX_ESC) begin
                            s.held_status  = ev;
                            s.meta_kind    = 8'h00;
                            s.varlen_accum = '0;
                            s.varlen_bytes = '0;
                            s.phase        = PH_LEN;
                            if (i_track_last) errk = K_BAD_LEN;
                        end else begin
                            errk = K_UNHANDLED;
                        end
                    end else if (ev[7]) begin
                        s.held_status = ev;
                        if (i_byte_value[7]) begin
                            s.phase = PH_DATA1;
                            if (i_track_last) errk = K_BAD_LEN;
                        end else if (ev[7:5] == 3'b110) begin
                            res  = 1'b1;
                            st   = ev;
                            d1   = i_byte_value;
                            cnt  = 2'd1;
                            done = 1'b1;
                        end else begin
                            s.held_data = i_byte_value;
                            s.phase     = PH_DATA2;
                            if (i_track_last) errk = K_BAD_LEN;
                        end
                    end else begin
                        errk = K_UNDEFINED;
                    end
                end
                PH_DATA1: begin
                    if (s.held_status[7:5] == 3'b110) begin
                        res  = 1'b1;
                        st   = s.held_status;
                        d1   = i_byte_value;
                        cnt  = 2'd1;
                        done = 1'b1;
                    end else begin
                        s.held_data = i_byte_value;
                        s.phase     = PH_DATA2;
                        if (i_track_last) errk = K_BAD_LEN;
                    end
                end
                PH_DATA2: begin
                    res  = 1'b1;
                    st   = s.held_status;
                    d1   = s.held_data;
                    d2   = i_byte_value;
                    cnt  = 2'd2;
                    done = 1'b1;
                end
                PH_MTYPE: begin
                    s.meta_kind    = i_byte_value;
                    s.varlen_accum = '0;
                    s.varlen_bytes = '0;
                    s.phase        = PH_LEN;
                    if (i_track_last) errk = K_BAD_LEN;
                end
                PH_LEN: begin
                    s.varlen_accum = vl_acc;
                    s.varlen_bytes = vl_cnt;
                    if (!i_byte_value[7]) begin
                        s.payload_remaining = vl_acc;
                        s.varlen_accum      = '0;
                        s.varlen_bytes      = '0;
                        s.tempo_capture     = '0;
                        if (vl_acc == 28'd0) begin
                            done = 1'b1;
                        end else begin
                            s.phase = PH_PAYLOAD;
                            if (i_track_last) errk = K_BAD_LEN;
                        end
                    end else if (vl_cnt >= 3'd4 || i_track_last) begin
                        errk = K_BAD_LEN;
                    end
                end
                default: begin
                    // payload byte: capture up to three tempo bytes
                    if (is_tempo_meta && s.varlen_bytes < 3'd3) begin
                        s.tempo_capture = {s.tempo_capture[15:0], i_byte_value};
                        s.varlen_bytes  = vl_cnt;
                    end
                    s.payload_remaining = s.payload_remaining - 28'd1;
                    if (s.payload_remaining == 28'd0) begin
                        done = 1'b1;
                    end else if (i_track_last) begin
                        errk = K_BAD_LEN;
                    end
                end
            endcase

            // finished tempo meta: left-align a short payload
            if (done && (ph == PH_LEN || ph == PH_PAYLOAD) && is_tempo_meta) begin
                unique case (s.varlen_bytes)
                    3'd0:    tempo_fixed = 24'h0;
                    3'd1:    tempo_fixed = {s.tempo_capture[7:0], 16'h0};
                    3'd2:    tempo_fixed = {s.tempo_capture[15:0], 8'h0};
                    default: tempo_fixed = s.tempo_capture;
                endcase
                s.tempo_capture = tempo_fixed;
                s.tempo_current = (tempo_fixed != 24'h0) ? tempo_fixed : TEMPO_DEFAULT;
                res  = 1'b1;
                kind = K_TEMPO;
            end

            // error, event completion or end of track
            if (errk != K_CHANNEL) begin
                res      = 1'b1;
                kind     = errk;
                st       = 8'h00;
                d1       = 8'h00;
                d2       = 8'h00;
                cnt      = 2'd0;
                s.halted = 1'b1;
            end else if (done) begin
                if (s.held_status < ST_REALTIME) begin
                    s.last_status = s.held_status;
                end
                if (i_track_last) begin
                    s.halted = 1'b1;
                    if (!res) begin
                        res  = 1'b1;
                        kind = K_END;
                    end
                end else begin
                    s.phase        = PH_DELTA;
                    s.varlen_accum = '0;
                    s.varlen_bytes = '0;
                end
            end else if (end_trk) begin
                res      = 1'b1;
                kind     = K_END;
                s.halted = 1'b1;
            end
        end
    end

    assign o_state                 = s;
    assign o_pulse                 = pulse;
    assign o_result_valid          = res;
    assign o_result.kind           = kind;
    assign o_result.status_byte    = st;
    assign o_result.first_data     = d1;
    assign o_result.second_data    = d2;
    assign o_result.data_count     = cnt;
    assign o_result.tempo_value    = s.tempo_current;
    assign o_result.track_ended    = res && s.halted;

endmodule

// File: tb/sv/midi_track_event_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser_tb
// Drives track payload bytes through the parser and predicts every channel
// message, tempo change, track end and error report it should produce.
// Directed tracks cover the corner cases, random tracks with random idling
// cover the rest.
// ----------------------------------------------------------------------------
module midi_track_event_parser_tb;
    import mtep_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int BYTE_TARGET = 750;

    // one predicted result with its pulse count
    typedef struct {
        t_result     res;
        logic [47:0] pulse;
    } t_midi_event;

    // predicts parser results per byte and checks them in order
    class t_event_board;
        logic [2:0]  phase;
        logic [7:0]  run_status;
        logic [7:0]  held_status;
        logic [7:0]  held_data;
        logic [7:0]  meta_type;
        logic [47:0] pulses;
        logic [27:0] vl_accum;
        logic [27:0] remaining;
        int unsigned vl_count;
        logic [23:0] tempo_cap;
        logic [23:0] tempo_now;
        bit          halted;
        t_midi_event pending_events[$];
        int unsigned mismatches;
        int unsigned parsed_bytes;

        function new();
            restart_track();
            remaining    = '0;
            meta_type    = '0;
            held_status  = '0;
            held_data    = '0;
            tempo_cap    = '0;
            tempo_now    = TEMPO_DEFAULT;
            mismatches   = 0;
            parsed_bytes = 0;
        endfunction

        function void restart_track();
            pulses     = '0;
            run_status = ST_META;
            halted     = 1'b0;
            phase      = PH_DELTA;
            vl_accum   = '0;
            vl_count   = 0;
        endfunction

        // work out the result, if any, of one accepted byte
        function void take_byte(logic [7:0] b, logic first, logic last);
            t_result     r;
            t_midi_event e;
            logic [7:0]  ev;
            logic [2:0]  fail_kind;
            bit          fail;
            bit          emit;
            bit          done;
            bit          stop;
            int unsigned keep;
            r = '0;
            fail_kind = K_BAD_LEN;
            fail = 1'b0;
            emit = 1'b0;
            done = 1'b0;
            stop = 1'b0;
            parsed_bytes++;
            if (first)
                restart_track();
            if (halted)
                return;

            case (phase)
                PH_DELTA: begin
                    vl_accum = {vl_accum[20:0], b[6:0]};
                    vl_count++;
                    if (!b[7]) begin
                        pulses = pulses + {20'd0, vl_accum};
                        vl_accum = '0;
                        vl_count = 0;
                        if (last)
                            stop = 1'b1;
                        else
                            phase = PH_STATUS;
                    end else if (vl_count >= 4 || last) begin
                        stop = 1'b1;
                    end
                end
                PH_STATUS: begin
                    ev = b[7] ? b : run_status;
                    if (!ev[7])
                        ev = '0;
                    if (ev[7:4] == 4'hF) begin
                        if (ev == ST_META) begin
                            held_status = ev;
                            phase = PH_MTYPE;
                            fail = last;
                        end else if (ev == ST_SYSEX || ev == ST_SYSEX_ESC) begin
                            held_status = ev;
                            meta_type = '0;
                            vl_accum = '0;
                            vl_count = 0;
                            phase = PH_LEN;
                            fail = last;
                        end else begin
                            fail = 1'b1;
                            fail_kind = K_UNHANDLED;
                        end
                    end else if (ev[7]) begin
                        held_status = ev;
                        if (b[7]) begin
                            phase = PH_DATA1;
                            fail = last;
                        end else if (ev[7:5] == 3'b110) begin
                            emit = 1'b1;
                            r.kind = K_CHANNEL;
                            r.status_byte = ev;
                            r.first_data = b;
                            r.data_count = 2'd1;
                            done = 1'b1;
                        end else begin
                            held_data = b;
                            phase = PH_DATA2;
                            fail = last;
                        end
                    end else begin
                        fail = 1'b1;
                        fail_kind = K_UNDEFINED;
                    end
                end
                PH_DATA1: begin
                    if (held_status[7:5] == 3'b110) begin
                        emit = 1'b1;
                        r.kind = K_CHANNEL;
                        r.status_byte = held_status;
                        r.first_data = b;
                        r.data_count = 2'd1;
                        done = 1'b1;
                    end else begin
                        held_data = b;
                        phase = PH_DATA2;
                        fail = last;
                    end
                end
                PH_DATA2: begin
                    emit = 1'b1;
                    r.kind = K_CHANNEL;
                    r.status_byte = held_status;
                    r.first_data = held_data;
                    r.second_data = b;
                    r.data_count = 2'd2;
                    done = 1'b1;
                end
                PH_MTYPE: begin
                    meta_type = b;
                    vl_accum = '0;
                    vl_count = 0;
                    phase = PH_LEN;
                    fail = last;
                end
                PH_LEN: begin
                    vl_accum = {vl_accum[20:0], b[6:0]};
                    vl_count++;
                    if (!b[7]) begin
                        remaining = vl_accum;
                        vl_accum = '0;
                        vl_count = 0;
                        tempo_cap = '0;
                        if (remaining == 0) begin
                            done = 1'b1;
                        end else begin
                            phase = PH_PAYLOAD;
                            fail = last;
                        end
                    end else if (vl_count >= 4 || last) begin
                        fail = 1'b1;
                    end
                end
                default: begin
                    // only the first three tempo bytes are captured
                    if (held_status == ST_META && meta_type == META_TEMPO && vl_count < 3) begin
                        tempo_cap = {tempo_cap[15:0], b};
                        vl_count++;
                    end
                    remaining = remaining - 28'd1;
                    if (remaining == 0)
                        done = 1'b1;
                    else if (last)
                        fail = 1'b1;
                end
            endcase

            // tempo meta complete: pad short payloads, zero means default
            if (done && (phase == PH_LEN || phase == PH_PAYLOAD) &&
                held_status == ST_META && meta_type == META_TEMPO) begin
                keep = (vl_count > 3) ? 3 : vl_count;
                tempo_cap = tempo_cap << (8 * (3 - keep));
                tempo_now = (tempo_cap != 0) ? tempo_cap : TEMPO_DEFAULT;
                emit = 1'b1;
                r.kind = K_TEMPO;
            end

            if (fail) begin
                r = '0;
                r.kind = fail_kind;
                r.track_ended = 1'b1;
                emit = 1'b1;
                halted = 1'b1;
            end else if (done) begin
                if (held_status < ST_REALTIME)
                    run_status = held_status;
                if (last) begin
                    halted = 1'b1;
                    r.track_ended = 1'b1;
                    if (!emit) begin
                        emit = 1'b1;
                        r.kind = K_END;
                    end
                end else begin
                    phase = PH_DELTA;
                    vl_accum = '0;
                    vl_count = 0;
                end
            end else if (stop) begin
                emit = 1'b1;
                r.kind = K_END;
                r.track_ended = 1'b1;
                halted = 1'b1;
            end

            if (emit) begin
                r.tempo_value = tempo_now;
                e.res = r;
                e.pulse = pulses;
                pending_events.push_back(e);
            end
        endfunction

        function void show(string tag, t_result r, logic [47:0] p);
            $display("%s kind=%0d st=%h d1=%h d2=%h cnt=%0d pulse=%0d tempo=%0d end=%b",
                     tag, r.kind, r.status_byte, r.first_data, r.second_data,
                     r.data_count, p, r.tempo_value, r.track_ended);
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_event(t_result got, logic [47:0] got_pulse);
            t_midi_event want;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    show("unexpected result:", got, got_pulse);
                return;
            end
            want = pending_events.pop_front();
            if (want.res !== got || want.pulse !== got_pulse) begin
                mismatches++;
                if (mismatches <= 10) begin
                    show("mismatch expected:", want.res, want.pulse);
                    show("         actual:  ", got, got_pulse);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_byte_value = '0;
    logic        i_track_start = 1'b0;
    logic        i_track_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_status_byte;
    logic [7:0]  o_first_data;
    logic [7:0]  o_second_data;
    logic [1:0]  o_data_count;
    logic [47:0] o_pulse_count;
    logic [23:0] o_tempo_value;
    logic        o_track_ended;

    t_event_board    board = new();
    t_result         seen_res;
    int              quiet_cycles = 0;
    int              in_idle_pct = 36;
    int              out_idle_pct = 36;
    logic [7:0]      track_bytes[$];
    logic [7:0]      gen_status;

    midi_track_event_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_byte_value  (i_byte_value),
        .i_track_start (i_track_start),
        .i_track_last  (i_track_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_status_byte (o_status_byte),
        .o_first_data  (o_first_data),
        .o_second_data (o_second_data),
        .o_data_count  (o_data_count),
        .o_pulse_count (o_pulse_count),
        .o_tempo_value (o_tempo_value),
        .o_track_ended (o_track_ended)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls at random
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_res = {o_kind, o_status_byte, o_first_data, o_second_data,
                        o_data_count, o_tempo_value, o_track_ended};
            board.check_event(seen_res, o_pulse_count);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // one byte transfer, entered and left at a falling edge
    task automatic send_byte(logic [7:0] b, logic first, logic last);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_byte_value  <= b;
        i_track_start <= first;
        i_track_last  <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        board.take_byte(b, first, last);
        @(negedge i_clk);
    endtask

    task automatic send_track(bit first, bit last);
        foreach (track_bytes[i])
            send_byte(track_bytes[i], first && i == 0,
                      last && i == track_bytes.size() - 1);
        track_bytes.delete();
    endtask

    // hold the sender until every predicted result has arrived
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.pending_events.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic void put(logic [7:0] b);
        track_bytes.push_back(b);
    endfunction

    // varlen number, possibly padded with leading zero groups
    function automatic void put_varlen(int unsigned value, int nb);
        logic [7:0] group;
        for (int i = nb - 1; i >= 0; i--) begin
            group = 8'((value >> (7 * i)) & 32'h7F);
            if (i > 0)
                group[7] = 1'b1;
            put(group);
        end
    endfunction

    function automatic void put_delta();
        int nb;
        nb = ($urandom_range(99) < 70) ? 1 : $urandom_range(4, 2);
        if ($urandom_range(99) < 15)
            put_varlen(0, nb);
        else
            put_varlen($urandom & ((32'd1 << (7 * nb)) - 1), nb);
    endfunction

    function automatic logic [7:0] data_byte();
        return ($urandom_range(99) < 85) ? 8'($urandom_range(127)) : 8'($urandom_range(255, 128));
    endfunction

    // length field and payload of a meta or sysex event
    function automatic void put_body(int unsigned len, bit zeros);
        put_varlen(len, ($urandom_range(99) < 85) ? 1 : 2);
        repeat (len)
            put(zeros ? 8'h00 : 8'($urandom));
    endfunction

    function automatic void put_running_data();
        put(8'($urandom_range(127)));
        if (gen_status[7:5] != 3'b110)
            put(data_byte());
    endfunction

    function automatic void put_event();
        int          pick;
        int unsigned len;
        logic [7:0]  st;
        pick = $urandom_range(99);
        if (pick < 50) begin
            // channel message, sometimes under running status
            if (gen_status >= 8'h80 && gen_status < ST_SYSEX && $urandom_range(99) < 35) begin
                put_running_data();
            end else begin
                st = 8'($urandom_range(8'hEF, 8'h80));
                put(st);
                put(data_byte());
                if (st[7:5] != 3'b110)
                    put(data_byte());
                gen_status = st;
            end
        end else if (pick < 68) begin
            put(ST_META);
            put(META_TEMPO);
            len = ($urandom_range(99) < 70) ? 3 : $urandom_range(5);
            put_body(len, $urandom_range(99) < 20);
        end else if (pick < 80) begin
            put(ST_META);
            put(8'($urandom));
            put_body($urandom_range(6), 1'b0);
        end else if (pick < 90) begin
            st = $urandom_range(1) ? ST_SYSEX : ST_SYSEX_ESC;
            put(st);
            put_body($urandom_range(6), 1'b0);
            gen_status = st;
        end else if (gen_status >= ST_SYSEX) begin
            // data byte standing in for the meta or sysex marker
            put(8'($urandom_range(127)));
            if (gen_status == ST_META)
                put(($urandom_range(99) < 40) ? META_TEMPO : 8'($urandom));
            put_body($urandom_range(4), 1'b0);
        end else begin
            put_running_data();
        end
    endfunction

    // one random track with a random kind of ending
    task automatic random_track();
        int         ending;
        int         keep;
        bit         mark_last;
        logic [7:0] st;
        gen_status = ST_META;
        mark_last = 1'b1;
        repeat ($urandom_range(6, 1)) begin
            put_delta();
            put_event();
        end
        ending = $urandom_range(99);
        if (ending < 55) begin
            // ends right after a complete event
        end else if (ending < 65) begin
            if ($urandom_range(1))
                repeat ($urandom_range(3, 1)) put(8'($urandom_range(255, 128)));
            else
                put_delta();
        end else if (ending < 75) begin
            keep = $urandom_range(track_bytes.size(), 1);
            while (track_bytes.size() > keep)
                void'(track_bytes.pop_back());
        end else if (ending < 82) begin
            put_delta();
            do
                st = 8'($urandom_range(8'hFE, 8'hF1));
            while (st == ST_SYSEX_ESC);
            put(st);
            repeat ($urandom_range(2)) put(8'($urandom));
        end else if (ending < 88) begin
            put_delta();
            if ($urandom_range(1)) begin
                put(ST_META);
                put(8'($urandom));
            end else begin
                put(ST_SYSEX);
            end
            repeat (4) put(8'($urandom_range(255, 128)));
            repeat ($urandom_range(2)) put(8'($urandom));
        end else if (ending < 93) begin
            repeat (4) put(8'($urandom_range(255, 128)));
            repeat ($urandom_range(2)) put(8'($urandom));
        end else begin
            mark_last = 1'b0;
        end
        send_track(1'b1, mark_last);
    endtask

    initial begin
        bit drained;
        drained = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bytes before any track start, one-byte message with top data bit
        put(8'h00); put(8'hC0); put(8'hFF);
        send_track(1'b0, 1'b0);
        // running status 0xFF as meta marker with short tempo, two-byte
        // message, running channel status, end-of-track meta on last byte
        put(8'h00); put(8'h7F); put(META_TEMPO); put(8'h02); put(8'h12); put(8'h34);
        put(8'h7F); put(8'h90); put(8'h80); put(8'hFF);
        put(8'h00); put(8'h01); put(8'h02);
        put(8'h00); put(ST_META); put(8'h2F); put(8'h00);
        send_track(1'b1, 1'b1);
        // empty sysex, data byte as sysex marker, over-long delta
        put(8'h00); put(ST_SYSEX); put(8'h00);
        put(8'h00); put(8'h00); put(8'h00);
        put(8'h81); put(8'h82); put(8'h83); put(8'h84);
        send_track(1'b1, 1'b1);
        drain_results();

        // random tracks with some noise between them
        while (board.parsed_bytes < BYTE_TARGET) begin
            if (board.parsed_bytes > 250 && board.parsed_bytes < 400) begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct = 36;
                out_idle_pct = 36;
            end
            if ($urandom_range(99) < 8) begin
                repeat ($urandom_range(6, 1))
                    send_byte(8'($urandom), $urandom_range(99) < 15, $urandom_range(99) < 15);
            end else begin
                random_track();
            end
            if (!drained && board.parsed_bytes > 450) begin
                drain_results();
                drained = 1'b1;
            end
        end
        i_in_valid <= 1'b0;

        while (board.pending_events.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.pending_events.size() != 0) begin
            $display("%0d predicted results never arrived", board.pending_events.size());
            board.mismatches += board.pending_events.size();
        end

        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
design/mtep_pkg.sv
design/mtep_step.sv
design/midi_track_event_parser.sv
tb/sv/midi_track_event_parser_tb.sv
